>>> rtl/lfbr_pkg.sv
// ----------------------------------------------------------------------------
// lfbr_pkg
// Shared types and constants of the length framed byte router.
// ----------------------------------------------------------------------------
`default_nettype none

package lfbr_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 9;

	// framer phase codes
	localparam logic [1:0] PH_HDR1 = 2'd0;
	localparam logic [1:0] PH_HDR2 = 2'd1;
	localparam logic [1:0] PH_PAY  = 2'd2;

	localparam logic [BYTE_W-1:0] HEADER_PAIR = 8'd2;

	// destination port codes
	localparam logic DEST_BOARD  = 1'b0;
	localparam logic DEST_CAMERA = 1'b1;

	// framer to drain sequencer: frame complete, where to and how long
	typedef struct packed {
		logic             start;
		logic             dest;
		logic [LEN_W-1:0] len;
	} drain_req_t;

	// sequencer to ring: write one received word, read one word
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ring_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lfbr_ring.sv
// ----------------------------------------------------------------------------
// lfbr_ring
// Byte ring in a synchronous memory with read and write pointers; a write to
// a full ring drops the oldest word. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbr_ring #(
	parameter int RING_DEPTH = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lfbr_pkg::ring_ctl_t       ctl,
	input  wire logic [lfbr_pkg::BYTE_W-1:0] wr_data,
	output logic [lfbr_pkg::BYTE_W-1:0]    rd_data_s1,
	output logic                           one_left
);
	import lfbr_pkg::*;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	logic [BYTE_W-1:0] mem [RING_DEPTH];
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_next;
	logic [PTR_W-1:0]  wr_next;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign rd_next  = ptr_next(rd_ptr_q);
	assign wr_next  = ptr_next(wr_ptr_q);
	// the word at the read pointer is the only one held
	assign one_left = (rd_next == wr_ptr_q);

	// reads and writes never share a cycle: writes only while no drain runs
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (ctl.wr_en) begin
				wr_ptr_q <= wr_next;
				// ring full: step past the oldest word
				if (wr_next == rd_ptr_q) begin
					rd_ptr_q <= rd_next;
				end
			end else if (ctl.rd_en) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/lfbr_framer.sv
// ----------------------------------------------------------------------------
// lfbr_framer
// Three-phase header parser: decides frame length and destination and flags
// the word that completes a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbr_framer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic [lfbr_pkg::BYTE_W-1:0] rx_byte,
	output lfbr_pkg::drain_req_t             req
);
	import lfbr_pkg::*;

	logic [1:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
	logic [LEN_W-1:0]  frame_len_q, frame_len_d;
	logic [BYTE_W-1:0] bl_dec;

	assign bl_dec = bytes_left_q - 8'd1;

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		frame_len_d  = frame_len_q;
		req          = '0;
		if (en) begin
			if (bl_dec != '0) begin
				bytes_left_d = bl_dec;
			end else begin
				unique case (phase_q)
					PH_HDR2: begin
						if (rx_byte == '0) begin
							req          = '{start: 1'b1, dest: DEST_CAMERA, len: frame_len_q};
							phase_d      = PH_HDR1;
							bytes_left_d = HEADER_PAIR;
							frame_len_d  = LEN_W'(HEADER_PAIR);
						end else begin
							phase_d      = PH_PAY;
							bytes_left_d = rx_byte;
							frame_len_d  = frame_len_q + LEN_W'(rx_byte);
						end
					end
					PH_PAY: begin
						req          = '{start: 1'b1, dest: DEST_CAMERA, len: frame_len_q};
						phase_d      = PH_HDR1;
						bytes_left_d = HEADER_PAIR;
						frame_len_d  = LEN_W'(HEADER_PAIR);
					end
					default: begin
						// first header pair, and the unused code
						if (rx_byte == '0) begin
							phase_d      = PH_HDR2;
							bytes_left_d = HEADER_PAIR;
							frame_len_d  = frame_len_q + LEN_W'(HEADER_PAIR);
						end else begin
							req          = '{start: 1'b1, dest: DEST_BOARD, len: frame_len_q};
							phase_d      = PH_HDR1;
							bytes_left_d = HEADER_PAIR;
							frame_len_d  = LEN_W'(HEADER_PAIR);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR1;
			bytes_left_q <= HEADER_PAIR;
			frame_len_q  <= LEN_W'(HEADER_PAIR);
		end else begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			frame_len_q  <= frame_len_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/length_framed_byte_router.sv
// ----------------------------------------------------------------------------
// length_framed_byte_router
// Stores received bytes in a ring and, at each frame end, forwards the ring
// contents to the board or camera port.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid/rx_ready, rx_byte) takes one received byte per word.
//   tx channel (tx_valid/tx_ready) gives out_byte, destination, last_of_frame
//   and short_frame, one word per forwarded byte.
//   A byte that does not end a frame leaves rx_ready high.
//   A byte that ends a frame starts a drain of n = min(frame length, bytes in
//   the ring) words, n at most RING_DEPTH-1. The drain reads the ring memory
//   one word per cycle when tx is not stalled, and rx_ready is low while it
//   runs. The memory read register and the tx output register form a two-word
//   pipeline that every tx word passes through: a stalled tx holds its word
//   and pauses the drain, while rx is taken again as soon as the last read of
//   the drain is issued.
//   If the ring empties first, the last word carries short_frame.
//   Reset empties the ring and returns the framer to the first header pair;
//   ring contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module length_framed_byte_router #(
	parameter int RING_DEPTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rx_valid,
	output logic                             rx_ready,
	input  wire logic [lfbr_pkg::BYTE_W-1:0] rx_byte,
	output logic                             tx_valid,
	input  wire logic                        tx_ready,
	output logic [lfbr_pkg::BYTE_W-1:0]      out_byte,
	output logic                             destination,
	output logic                             last_of_frame,
	output logic                             short_frame
);
	import lfbr_pkg::*;

	logic              rx_take;
	drain_req_t        req;
	ring_ctl_t         ring_ctl;
	logic [BYTE_W-1:0] rd_data_s1;
	logic              one_left;

	logic              draining_q;
	logic              dest_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  sent_q;
	logic [LEN_W-1:0]  sent_next;
	logic              issue;
	logic              last_iss;
	logic              short_iss;

	logic              valid_s1;
	logic              dest_s1;
	logic              last_s1;
	logic              short_s1;
	logic              move_out;

	logic              tx_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              dest_out_q;
	logic              last_q;
	logic              short_q;

	assign rx_ready = !draining_q;
	assign rx_take  = rx_valid && rx_ready;

	lfbr_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (rx_take),
		.rx_byte (rx_byte),
		.req     (req)
	);

	assign move_out  = valid_s1 && (!tx_valid_q || tx_ready);
	assign issue     = draining_q && (!valid_s1 || move_out);
	assign sent_next = sent_q + 1'b1;
	assign last_iss  = (sent_next == len_q) || one_left;
	assign short_iss = one_left && (sent_next != len_q);

	assign ring_ctl = '{wr_en: rx_take, rd_en: issue};

	lfbr_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ring_ctl),
		.wr_data    (rx_byte),
		.rd_data_s1 (rd_data_s1),
		.one_left   (one_left)
	);

	// drain sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			sent_q     <= '0;
		end else if (rx_take && req.start) begin
			draining_q <= 1'b1;
			sent_q     <= '0;
		end else if (issue) begin
			sent_q <= sent_next;
			if (last_iss) begin
				draining_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take && req.start) begin
			dest_q <= req.dest;
			len_q  <= req.len;
		end
	end

	// read stage, alongside the memory read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (move_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			dest_s1  <= dest_q;
			last_s1  <= last_iss;
			short_s1 <= short_iss;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid_q <= 1'b0;
		end else if (move_out) begin
			tx_valid_q <= 1'b1;
		end else if (tx_ready) begin
			tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			out_byte_q <= rd_data_s1;
			dest_out_q <= dest_s1;
			last_q     <= last_s1;
			short_q    <= short_s1;
		end
	end

	assign tx_valid      = tx_valid_q;
	assign out_byte      = out_byte_q;
	assign destination   = dest_out_q;
	assign last_of_frame = last_q;
	assign short_frame   = short_q;

endmodule

`default_nettype wire

>>> rtl/lfbr_checker.sv
// ----------------------------------------------------------------------------
// lfbr_checker
// Port-level checks of the length framed byte router, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_valid,
	input wire logic       rx_ready,
	input wire logic       tx_valid,
	input wire logic       tx_ready,
	input wire logic [7:0] out_byte,
	input wire logic       destination,
	input wire logic       last_of_frame,
	input wire logic       short_frame
);

	// stalled tx word holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(out_byte) && $stable(destination)
			&& $stable(last_of_frame) && $stable(short_frame))
		else $error("tx word changed while stalled");

	// short frame only marked on the closing word
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && short_frame |-> last_of_frame)
		else $error("short_frame without last_of_frame");

	// every word of one frame goes to the same port
	a_dest_frame: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && !last_of_frame |=> !tx_valid
			|| destination == $past(destination))
		else $error("destination changed inside a frame");

	// rx stops only after a word has been taken
	a_rx_block: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rx_ready) |-> $past(rx_valid && rx_ready))
		else $error("rx_ready fell without an accepted word");

endmodule

bind length_framed_byte_router lfbr_checker u_lfbr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx_valid),
	.rx_ready      (rx_ready),
	.tx_valid      (tx_valid),
	.tx_ready      (tx_ready),
	.out_byte      (out_byte),
	.destination   (destination),
	.last_of_frame (last_of_frame),
	.short_frame   (short_frame)
);

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the length framed byte router and checks every
// forwarded word against a behavioural copy of the framer and ring. A short
// table of hand-picked bytes comes first, then two fixed frames and random
// frames, with random idle gaps on the rx side and random stalls on the tx side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import lfbr_pkg::*;

	localparam int DEPTH       = 32;
	localparam int UNTYPED     = -1;
	localparam int TOTAL_BYTES = 470;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              dest;
		logic              last;
		logic              shrt;
	} fwd_word_t;

	typedef struct {
		logic [BYTE_W-1:0] rx;
		int                n_words;
		logic [BYTE_W-1:0] last_b;
		logic              dest;
		logic              shrt;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              rx_valid = 1'b0;
	logic              rx_ready;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              tx_valid;
	logic              tx_ready = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              destination;
	logic              last_of_frame;
	logic              short_frame;

	// behavioural copy of the ring and framer
	logic [BYTE_W-1:0] ring_mem [DEPTH];
	int                rd_idx = 0;
	int                wr_idx = 0;
	logic [1:0]        fr_phase = PH_HDR1;
	logic [7:0]        fr_left = HEADER_PAIR;
	logic [LEN_W-1:0]  fr_len = LEN_W'(HEADER_PAIR);

	fwd_word_t pending_words [$];

	int  err_count = 0;
	int  bytes_in = 0;
	int  words_out = 0;
	int  board_frames = 0;
	int  camera_frames = 0;
	int  short_frames = 0;
	logic calm = 1'b0;

	always #5 clk = ~clk;

	length_framed_byte_router #(.RING_DEPTH(DEPTH)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.tx_valid     (tx_valid),
		.tx_ready     (tx_ready),
		.out_byte     (out_byte),
		.destination  (destination),
		.last_of_frame(last_of_frame),
		.short_frame  (short_frame)
	);

	// no gap while calm; otherwise mostly none, sometimes a short gap, rarely a long wait
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one received byte through the framer; forwarded words go to the queue
	task automatic route_byte(input logic [BYTE_W-1:0] c, output int produced);
		logic [LEN_W-1:0] len;
		logic             dst;
		logic             go;
		int               nxt;
		int               sent;
		fwd_word_t        w;
		produced = 0;
		go = 1'b0;
		dst = DEST_BOARD;
		nxt = (wr_idx + 1) % DEPTH;
		// full ring: oldest byte is lost
		if (nxt == rd_idx)
			rd_idx = (rd_idx + 1) % DEPTH;
		ring_mem[wr_idx] = c;
		wr_idx = nxt;
		fr_left = fr_left - 8'd1;
		if (fr_left != 0)
			return;
		case (fr_phase)
			PH_HDR2: begin
				if (c == 0) begin
					go = 1'b1;
					dst = DEST_CAMERA;
				end else begin
					fr_phase = PH_PAY;
					fr_left = c;
					fr_len = fr_len + {1'b0, c};
				end
			end
			PH_PAY: begin
				go = 1'b1;
				dst = DEST_CAMERA;
			end
			default: begin
				if (c == 0) begin
					fr_phase = PH_HDR2;
					fr_left = HEADER_PAIR;
					fr_len = fr_len + LEN_W'(HEADER_PAIR);
				end else begin
					go = 1'b1;
					dst = DEST_BOARD;
				end
			end
		endcase
		if (!go)
			return;
		len = fr_len;
		fr_phase = PH_HDR1;
		fr_left = HEADER_PAIR;
		fr_len = LEN_W'(HEADER_PAIR);
		sent = 0;
		while (sent < int'(len) && rd_idx != wr_idx) begin
			w.out_byte = ring_mem[rd_idx];
			w.dest = dst;
			w.last = 1'b0;
			w.shrt = 1'b0;
			pending_words.push_back(w);
			rd_idx = (rd_idx + 1) % DEPTH;
			sent++;
		end
		w = pending_words.pop_back();
		w.last = 1'b1;
		w.shrt = (sent < int'(len));
		pending_words.push_back(w);
		produced = sent;
		if (dst == DEST_BOARD)
			board_frames++;
		else
			camera_frames++;
		if (w.shrt)
			short_frames++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, output int produced);
		int n;
		n = gap_len();
		if (n > 0) begin
			@(negedge clk);
			rx_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		rx_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_ready);
		route_byte(b, produced);
		bytes_in++;
	endtask

	task automatic send_frame(input int kind, input int pay_len);
		int dummy;
		int i;
		case (kind)
			0: begin
				send_byte(8'($urandom), dummy);
				send_byte(8'($urandom_range(1, 255)), dummy);
			end
			1: begin
				send_byte(8'($urandom), dummy);
				send_byte(8'h00, dummy);
				send_byte(8'($urandom), dummy);
				send_byte(8'h00, dummy);
			end
			default: begin
				send_byte(8'($urandom), dummy);
				send_byte(8'h00, dummy);
				send_byte(8'($urandom), dummy);
				send_byte(8'(pay_len), dummy);
				for (i = 0; i < pay_len; i++)
					send_byte(8'($urandom), dummy);
			end
		endcase
	endtask

	// tx side stalls
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				tx_ready <= 1'b0;
				stall_left--;
			end else begin
				tx_ready <= 1'b1;
				stall_left = gap_len();
			end
		end
	end

	// every accepted tx word against the oldest pending one
	always @(posedge clk) begin
		fwd_word_t w;
		if (arst_n && tx_valid && tx_ready) begin
			words_out++;
			if (pending_words.size() == 0) begin
				$error("tx word with nothing pending: out_byte %02h", out_byte);
				err_count++;
			end else begin
				w = pending_words.pop_front();
				if (out_byte !== w.out_byte) begin
					$error("out_byte: expected %02h, got %02h", w.out_byte, out_byte);
					err_count++;
				end
				if (destination !== w.dest) begin
					$error("destination: expected %0b, got %0b", w.dest, destination);
					err_count++;
				end
				if (last_of_frame !== w.last) begin
					$error("last_of_frame: expected %0b, got %0b", w.last, last_of_frame);
					err_count++;
				end
				if (short_frame !== w.shrt) begin
					$error("short_frame: expected %0b, got %0b", w.shrt, short_frame);
					err_count++;
				end
			end
		end
	end

	initial begin
		#100_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		dir_row_t  dir_rows [15];
		fwd_word_t w;
		int        produced;
		int        r;
		int        i;
		int        base;
		logic      pressed;

		dir_rows = '{
			'{8'h00, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'hFF, 2,       8'hFF, DEST_BOARD,  1'b0},
			'{8'hFF, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'h01, 2,       8'h01, DEST_BOARD,  1'b0},
			'{8'h80, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'h00, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'h7F, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'h00, 4,       8'h00, DEST_CAMERA, 1'b0},
			'{8'h55, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'h00, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'hAA, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'h03, 0,       8'h00, DEST_BOARD,  1'b0},
			'{8'h01, UNTYPED, 8'h00, DEST_BOARD,  1'b0},
			'{8'h02, UNTYPED, 8'h00, DEST_BOARD,  1'b0},
			'{8'hFF, 7,       8'hFF, DEST_CAMERA, 1'b0}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			send_byte(dir_rows[k].rx, produced);
			if (dir_rows[k].n_words != UNTYPED) begin
				if (produced != dir_rows[k].n_words) begin
					$error("words per frame: expected %0d, got %0d", dir_rows[k].n_words,
						produced);
					err_count++;
				end else if (produced > 0) begin
					w = pending_words[pending_words.size() - 1];
					if (w.out_byte !== dir_rows[k].last_b || w.dest !== dir_rows[k].dest ||
							w.shrt !== dir_rows[k].shrt) begin
						$error("final word of row %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
							k, dir_rows[k].last_b, dir_rows[k].dest, dir_rows[k].shrt,
							w.out_byte, w.dest, w.shrt);
						err_count++;
					end
				end
			end
		end

		// ring overflow with a short frame, then the longest payload
		send_frame(2, 28);
		send_frame(2, 255);

		base = bytes_in;
		pressed = 1'b0;
		while (bytes_in < TOTAL_BYTES) begin
			if ($urandom_range(0, 7) == 0)
				calm = ~calm;
			if (!pressed && bytes_in > (base + TOTAL_BYTES) / 2) begin
				pressed = 1'b1;
				@(negedge clk);
				rx_valid <= 1'b0;
				while (pending_words.size() != 0)
					@(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 8) begin
				// stray bytes knock the framer out of step
				for (i = 0; i < $urandom_range(1, 3); i++)
					send_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom), produced);
			end else if (r < 38)
				send_frame(0, 0);
			else if (r < 55)
				send_frame(1, 0);
			else if (r < 93)
				send_frame(2, $urandom_range(1, 27));
			else
				send_frame(2, $urandom_range(28, 60));
		end

		@(negedge clk);
		rx_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d bytes, checked %0d forwarded words", bytes_in, words_out);
		$display("frames: %0d board, %0d camera, %0d cut short by ring overflow",
			board_frames, camera_frames, short_frames);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/lfbr_pkg.sv
rtl/lfbr_ring.sv
rtl/lfbr_framer.sv
rtl/length_framed_byte_router.sv
rtl/lfbr_checker.sv
test/tb_top.sv
